// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the matrix inverse RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The condition holds in the same cycle as the trigger.
`define ASSERT_IMPLIES(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("assertion failed");
// The condition holds in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, trig, cond)
`define ASSERT_NEXT(label, clk, rst_n, trig, cond)
`endif
`endif

// ----- rtl/core/mi3_pkg.sv -----
// ----------------------------------------------------------------------------
// Matrix inverse package
// Pipeline latency constants shared by the determinant unit, the divider lanes and the top level.
// ----------------------------------------------------------------------------
`default_nettype none
package mi3_pkg;
  // Stages in a cofactor lane: products, then difference.
  localparam int COF_LAT = 2;
  // Stages in the determinant unit: partial products, then sum.
  localparam int DET_LAT = 2;
  // Divider stages ahead of the quotient steps: sign removal, range check.
  localparam int DIV_PRE_LAT = 2;
  // Divider stages after the quotient steps: saturation.
  localparam int DIV_POST_LAT = 1;
endpackage
`default_nettype wire

// ----- rtl/core/mi3_cof.sv -----
// ----------------------------------------------------------------------------
// Cofactor lane
// Forms one 2x2 cofactor a*b - c*d exactly over two pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none
module mi3_cof #(
  parameter int ENTRY_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic signed [ENTRY_WIDTH-1:0]   a_i,
  input  wire logic signed [ENTRY_WIDTH-1:0]   b_i,
  input  wire logic signed [ENTRY_WIDTH-1:0]   c_i,
  input  wire logic signed [ENTRY_WIDTH-1:0]   d_i,
  output logic signed [2*ENTRY_WIDTH:0]        adj_o
);
  localparam int W  = ENTRY_WIDTH;
  localparam int CW = 2*W + 1;

  logic signed [2*W-1:0] p0_r, p1_r;
  logic signed [CW-1:0]  adj_r;

  // Both products are registered before the subtraction.
  always_ff @(posedge clk) begin
    if (en) begin
      p0_r  <= a_i * b_i;
      p1_r  <= c_i * d_i;
      adj_r <= CW'(p0_r) - CW'(p1_r);
    end
  end

  assign adj_o = adj_r;
endmodule
`default_nettype wire

// ----- rtl/core/mi3_det.sv -----
// ----------------------------------------------------------------------------
// Determinant unit
// Expands the determinant along the first row from the first adjugate column.
// ----------------------------------------------------------------------------
`default_nettype none
module mi3_det #(
  parameter int ENTRY_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic signed [ENTRY_WIDTH-1:0]   a_i [3],
  input  wire logic signed [2*ENTRY_WIDTH:0]   adj_i [3],
  output logic signed [3*ENTRY_WIDTH+1:0]      det_o
);
  import mi3_pkg::*;

  localparam int W  = ENTRY_WIDTH;
  localparam int CW = 2*W + 1;
  localparam int DW = 3*W + 2;

  logic signed [W-1:0]   a_d_r [COF_LAT][3];
  logic signed [2*W:0]   plo_r [3];
  logic signed [2*W:0]   phi_r [3];
  logic signed [DW-1:0]  det_r;

  // Row entries are delayed to meet the cofactors.
  always_ff @(posedge clk) begin
    if (en) begin
      a_d_r[0] <= a_i;
      for (int k = 1; k < COF_LAT; k++) a_d_r[k] <= a_d_r[k-1];
    end
  end

  // Each wide cofactor is split into a low unsigned and a high signed part.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        plo_r[k] <= a_d_r[COF_LAT-1][k] * $signed({1'b0, adj_i[k][W-1:0]});
        phi_r[k] <= a_d_r[COF_LAT-1][k] * $signed(adj_i[k][CW-1:W]);
      end
    end
  end

  // The partial products are recombined and summed.
  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= (DW'(phi_r[0]) <<< W) + DW'(plo_r[0])
             + (DW'(phi_r[1]) <<< W) + DW'(plo_r[1])
             + (DW'(phi_r[2]) <<< W) + DW'(plo_r[2]);
    end
  end

  assign det_o = det_r;
endmodule
`default_nettype wire

// ----- rtl/core/mi3_div.sv -----
// ----------------------------------------------------------------------------
// Divider lane
// Pipelined restoring division of a scaled cofactor by the determinant,
// one quotient bit per stage, with saturation to the entry range.
// ----------------------------------------------------------------------------
`default_nettype none
module mi3_div #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic signed [2*ENTRY_WIDTH:0]   adj_i,
  input  wire logic signed [3*ENTRY_WIDTH+1:0] det_i,
  output logic        [ENTRY_WIDTH-1:0]        res_o,
  output logic                                 sat_o
);
  import mi3_pkg::*;

  localparam int W   = ENTRY_WIDTH;
  localparam int CW  = 2*W + 1;
  localparam int DW  = 3*W + 2;
  localparam int NW  = CW + 2*FRAC_BITS;
  localparam int DXW = DW + W;
  localparam int RW  = ((NW > DXW) ? NW : DXW) + 1;

  logic signed [CW-1:0] adj_d_r [DET_LAT];
  logic [CW-1:0]        cmag;
  logic [DW-1:0]        dmag;
  logic [RW-1:0]        num_r, den_r;
  logic                 neg_r;
  logic [RW-1:0]        rem_r [W+1];
  logic [RW-1:0]        dp_r  [W+1];
  logic [W-1:0]         q_r   [W+1];
  logic                 negp_r [W+1];
  logic                 bigp_r [W+1];
  logic [W-1:0]         limit, mag;
  logic                 sat;
  logic [W-1:0]         res_r;
  logic                 sat_r;

  // The cofactor waits for the determinant.
  always_ff @(posedge clk) begin
    if (en) begin
      adj_d_r[0] <= adj_i;
      for (int k = 1; k < DET_LAT; k++) adj_d_r[k] <= adj_d_r[k-1];
    end
  end

  // Signs are removed and the numerator is scaled.
  always_comb begin
    cmag = adj_d_r[DET_LAT-1][CW-1] ? CW'(-adj_d_r[DET_LAT-1]) : CW'(adj_d_r[DET_LAT-1]);
    dmag = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= {{(RW-CW){1'b0}}, cmag} << (2*FRAC_BITS);
      den_r <= {{(RW-DW){1'b0}}, dmag};
      neg_r <= adj_d_r[DET_LAT-1][CW-1] ^ det_i[DW-1];
    end
  end

  // A quotient of 2^W or more can only saturate.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num_r;
      dp_r[0]   <= den_r;
      q_r[0]    <= '0;
      negp_r[0] <= neg_r;
      bigp_r[0] <= (num_r >= (den_r << W));
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 0; s < W; s++) begin : g_step
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = dp_r[s] << (W-1-s);
    assign ge    = (rem_r[s] >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]         <= ge ? (rem_r[s] - trial) : rem_r[s];
        q_r[s+1]           <= q_r[s] | (W'(ge) << (W-1-s));
        dp_r[s+1]          <= dp_r[s];
        negp_r[s+1]        <= negp_r[s];
        bigp_r[s+1]        <= bigp_r[s];
      end
    end
  end

  // The magnitude is clipped and the sign restored.
  always_comb begin
    limit = negp_r[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    sat   = bigp_r[W] || (q_r[W] > limit);
    mag   = sat ? limit : q_r[W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= negp_r[W] ? (W'(0) - mag) : mag;
      sat_r <= sat;
    end
  end

  assign res_o = res_r;
  assign sat_o = sat_r;
endmodule
`default_nettype wire

// ----- rtl/core/matrix3x3_inverse.sv -----
// ----------------------------------------------------------------------------
// 3x3 matrix inverse
// Inverse of a fixed-point 3x3 matrix by adjugate and exact division.
// ----------------------------------------------------------------------------
// One matrix is taken every cycle unless a result is stalled; its inverse
// passes through the cofactor lanes, the determinant unit and the nine
// divider lanes, which produce one quotient bit per pipeline stage.
// When a result is stalled the whole pipeline holds and no request is taken.
// A singular matrix returns zero entries with singular set; entries that do
// not fit the format are clipped and flagged by saturated.
`default_nettype none
`include "assert_macros.svh"
module matrix3x3_inverse #(
  parameter int FRAC_BITS   = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [ENTRY_WIDTH-1:0] in_m_r1c1,
  input  wire logic signed [ENTRY_WIDTH-1:0] in_m_r1c2,
  input  wire logic signed [ENTRY_WIDTH-1:0] in_m_r1c3,
  input  wire logic signed [ENTRY_WIDTH-1:0] in_m_r2c1,
  input  wire logic signed [ENTRY_WIDTH-1:0] in_m_r2c2,
  input  wire logic signed [ENTRY_WIDTH-1:0] in_m_r2c3,
  input  wire logic signed [ENTRY_WIDTH-1:0] in_m_r3c1,
  input  wire logic signed [ENTRY_WIDTH-1:0] in_m_r3c2,
  input  wire logic signed [ENTRY_WIDTH-1:0] in_m_r3c3,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [ENTRY_WIDTH-1:0]      out_inv_r1c1,
  output logic signed [ENTRY_WIDTH-1:0]      out_inv_r1c2,
  output logic signed [ENTRY_WIDTH-1:0]      out_inv_r1c3,
  output logic signed [ENTRY_WIDTH-1:0]      out_inv_r2c1,
  output logic signed [ENTRY_WIDTH-1:0]      out_inv_r2c2,
  output logic signed [ENTRY_WIDTH-1:0]      out_inv_r2c3,
  output logic signed [ENTRY_WIDTH-1:0]      out_inv_r3c1,
  output logic signed [ENTRY_WIDTH-1:0]      out_inv_r3c2,
  output logic signed [ENTRY_WIDTH-1:0]      out_inv_r3c3,
  output logic                               out_singular,
  output logic                               out_saturated
);
  import mi3_pkg::*;

  localparam int W    = ENTRY_WIDTH;
  localparam int CW   = 2*W + 1;
  localparam int DW   = 3*W + 2;
  localparam int LAT  = COF_LAT + DET_LAT + DIV_PRE_LAT + W + DIV_POST_LAT;
  localparam int SLAT = LAT - COF_LAT - DET_LAT;

  logic                  en;
  logic [LAT-1:0]        vld_r, vld_nxt;
  logic [SLAT-1:0]       sing_r;
  logic signed [W-1:0]   m [3][3];
  logic signed [CW-1:0]  adj [3][3];
  logic signed [W-1:0]   row0 [3];
  logic signed [CW-1:0]  adjc0 [3];
  logic signed [DW-1:0]  det;
  logic [W-1:0]          res [3][3];
  logic [8:0]            sat;
  logic                  sing;

  // The pipeline advances unless a finished result is held back.
  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !en;

  assign m[0][0] = in_m_r1c1;
  assign m[0][1] = in_m_r1c2;
  assign m[0][2] = in_m_r1c3;
  assign m[1][0] = in_m_r2c1;
  assign m[1][1] = in_m_r2c2;
  assign m[1][2] = in_m_r2c3;
  assign m[2][0] = in_m_r3c1;
  assign m[2][1] = in_m_r3c2;
  assign m[2][2] = in_m_r3c3;

  // Request valid bits travel beside the data.
  assign vld_nxt = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Nine cofactor lanes, one per adjugate entry, each with its divider lane.
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      mi3_cof #(.ENTRY_WIDTH(W)) u_cof (
        .clk   (clk),
        .en    (en),
        .a_i   (m[(j+1)%3][(i+1)%3]),
        .b_i   (m[(j+2)%3][(i+2)%3]),
        .c_i   (m[(j+1)%3][(i+2)%3]),
        .d_i   (m[(j+2)%3][(i+1)%3]),
        .adj_o (adj[i][j])
      );
      mi3_div #(.ENTRY_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .en    (en),
        .adj_i (adj[i][j]),
        .det_i (det),
        .res_o (res[i][j]),
        .sat_o (sat[i*3+j])
      );
    end
  end

  assign row0  = m[0];
  assign adjc0 = '{adj[0][0], adj[1][0], adj[2][0]};

  mi3_det #(.ENTRY_WIDTH(W)) u_det (
    .clk   (clk),
    .en    (en),
    .a_i   (row0),
    .adj_i (adjc0),
    .det_o (det)
  );

  // The singular flag follows the divider lanes to the output.
  always_ff @(posedge clk) begin
    if (en) begin
      sing_r <= {sing_r[SLAT-2:0], (det == '0)};
    end
  end

  // Merge: a singular matrix overrides every lane.
  assign sing          = sing_r[SLAT-1];
  assign out_valid     = vld_r[LAT-1];
  assign out_singular  = sing;
  assign out_saturated = !sing && (|sat);
  assign out_inv_r1c1  = sing ? '0 : res[0][0];
  assign out_inv_r1c2  = sing ? '0 : res[0][1];
  assign out_inv_r1c3  = sing ? '0 : res[0][2];
  assign out_inv_r2c1  = sing ? '0 : res[1][0];
  assign out_inv_r2c2  = sing ? '0 : res[1][1];
  assign out_inv_r2c3  = sing ? '0 : res[1][2];
  assign out_inv_r3c1  = sing ? '0 : res[2][0];
  assign out_inv_r3c2  = sing ? '0 : res[2][1];
  assign out_inv_r3c3  = sing ? '0 : res[2][2];

  // Checks on the pipeline control and the merge.
  `ASSERT_IMPLIES(a_sing_nosat, clk, rst_n, out_singular, !out_saturated)
  `ASSERT_IMPLIES(a_stall_full, clk, rst_n, in_stall, out_valid)
  `ASSERT_NEXT(a_hold_pipe, clk, rst_n, !en, $stable(vld_r))
endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// 3x3 matrix inverse testbench
// Drives Q16.16 matrices into the inverse pipeline and checks every result
// against an exact wide-integer prediction. Both channels idle at random.
// The receiver also holds off for long stretches so that the pipeline fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  localparam int FRAC = 16;
  localparam int EW   = 32;

  typedef logic signed [EW-1:0] entry_t;
  typedef entry_t matrix_t [9];
  typedef struct {
    entry_t inv [9];
    logic   singular;
    logic   saturated;
  } inverse_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  entry_t in_m [9];
  logic   out_valid;
  logic   out_stall;
  entry_t out_inv [9];
  logic   out_singular;
  logic   out_saturated;

  inverse_t pending_inverses [$];
  int       errors;
  bit       hold_req;

  matrix3x3_inverse #(.FRAC_BITS(FRAC), .ENTRY_WIDTH(EW)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_m_r1c1(in_m[0]), .in_m_r1c2(in_m[1]), .in_m_r1c3(in_m[2]),
    .in_m_r2c1(in_m[3]), .in_m_r2c2(in_m[4]), .in_m_r2c3(in_m[5]),
    .in_m_r3c1(in_m[6]), .in_m_r3c2(in_m[7]), .in_m_r3c3(in_m[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_inv_r1c1(out_inv[0]), .out_inv_r1c2(out_inv[1]), .out_inv_r1c3(out_inv[2]),
    .out_inv_r2c1(out_inv[3]), .out_inv_r2c2(out_inv[4]), .out_inv_r2c3(out_inv[5]),
    .out_inv_r3c1(out_inv[6]), .out_inv_r3c2(out_inv[7]), .out_inv_r3c3(out_inv[8]),
    .out_singular(out_singular), .out_saturated(out_saturated)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Exact inverse: adjugate over determinant, truncated toward zero, clipped.
  function automatic inverse_t invert_matrix(matrix_t m);
    logic signed [255:0] e [3][3];
    logic signed [255:0] adj [3][3];
    logic signed [255:0] det;
    logic [255:0] dmag, nmag, quo, limit;
    bit neg;
    inverse_t r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) e[i][j] = m[i*3+j];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        adj[i][j] = e[(j+1)%3][(i+1)%3] * e[(j+2)%3][(i+2)%3]
                  - e[(j+1)%3][(i+2)%3] * e[(j+2)%3][(i+1)%3];
    det = e[0][0]*adj[0][0] + e[0][1]*adj[1][0] + e[0][2]*adj[2][0];
    r.singular = 1'b0;
    r.saturated = 1'b0;
    if (det == 0) begin
      foreach (r.inv[k]) r.inv[k] = '0;
      r.singular = 1'b1;
      return r;
    end
    dmag = (det < 0) ? -det : det;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        nmag = (adj[i][j] < 0) ? -adj[i][j] : adj[i][j];
        nmag = nmag << (2*FRAC);
        quo = nmag / dmag;
        neg = (adj[i][j] < 0) != (det < 0);
        limit = 256'd1 << (EW-1);
        if (!neg) limit = limit - 1;
        if (quo > limit) begin
          quo = limit;
          r.saturated = 1'b1;
        end
        if (neg) quo = -quo;
        r.inv[i*3+j] = quo[EW-1:0];
      end
    end
    return r;
  endfunction

  // Idle length: mostly none, some short, a few long.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request and wait for it to be taken; then idle at random.
  task automatic send_matrix(matrix_t m);
    int gap;
    in_valid <= 1'b1;
    foreach (m[k]) in_m[k] <= m[k];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_inverses.push_back(invert_matrix(m));
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender pause until every expected inverse has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk);
  endtask

  // Result checking and receiver stalls, including a long counted hold-off.
  initial begin : result_side
    int stall_left;
    int hold_left;
    inverse_t want;
    stall_left = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_inverses.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = pending_inverses.pop_front();
          foreach (want.inv[k])
            if (out_inv[k] !== want.inv[k]) begin
              $error("inv_r%0dc%0d: expected %h, actual %h", k/3+1, k%3+1,
                     want.inv[k], out_inv[k]);
              errors++;
            end
          if (out_singular !== want.singular) begin
            $error("singular: expected %b, actual %b", want.singular, out_singular);
            errors++;
          end
          if (out_saturated !== want.saturated) begin
            $error("saturated: expected %b, actual %b", want.saturated, out_saturated);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = idle_cycles();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  function automatic matrix_t diag(entry_t a, entry_t b, entry_t c);
    matrix_t m;
    foreach (m[k]) m[k] = '0;
    m[0] = a; m[4] = b; m[8] = c;
    return m;
  endfunction

  function automatic matrix_t random_matrix(int kind);
    matrix_t m;
    foreach (m[k]) begin
      case (kind)
        0: m[k] = $urandom;
        1: m[k] = $signed($urandom_range(0, 'h3FFFF)) - 'h20000;
        default: m[k] = $signed($urandom_range(0, 'h7FF)) - 'h400;
      endcase
    end
    // Well-conditioned: strong diagonal.
    if (kind == 1) begin
      m[0] = m[0] + 32'sh0008_0000;
      m[4] = m[4] - 32'sh0008_0000;
      m[8] = m[8] + 32'sh0008_0000;
    end
    return m;
  endfunction

  // Extremes, identity, singular and saturating cases.
  task automatic test_directed();
    matrix_t m;
    send_matrix(diag(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
    send_matrix(diag(32'sh0002_0000, -32'sh0004_0000, 32'sh0000_8000));
    send_matrix(diag('0, '0, '0));
    send_matrix(diag(32'sh1, 32'sh1, 32'sh1));
    send_matrix(diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_matrix(diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_matrix(diag(32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh1));
    foreach (m[k]) m[k] = 32'sh7FFF_FFFF;
    send_matrix(m);
    foreach (m[k]) m[k] = 32'sh8000_0000;
    send_matrix(m);
    foreach (m[k]) m[k] = -32'sh1;
    send_matrix(m);
    // Permutation and equal rows.
    m = diag('0, '0, '0);
    m[1] = 32'sh0001_0000; m[5] = 32'sh0001_0000; m[6] = 32'sh0001_0000;
    send_matrix(m);
    m = random_matrix(1);
    m[3] = m[0]; m[4] = m[1]; m[5] = m[2];
    send_matrix(m);
    for (int k = 0; k < 3; k++) send_matrix(random_matrix(k));
    drain();
  endtask

  // Long receiver hold-off while the sender keeps offering requests.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int n = 0; n < 80; n++) send_matrix(random_matrix(1));
    drain();
  endtask

  // Random matrices of mixed kinds, with some singular ones.
  task automatic test_random(int count);
    matrix_t m;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 9);
      m = random_matrix(r < 3 ? 0 : (r < 8 ? 1 : 2));
      if (r == 9) begin
        m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
      end
      send_matrix(m);
      if (n == count / 2) drain();
    end
  endtask

  // Stimulus sequence.
  initial begin
    errors = 0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    foreach (in_m[k]) in_m[k] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(560);
    in_valid <= 1'b0;
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
